FILE: hdl/vga_mrg_pkg.sv
package vga_mrg_pkg;

  localparam int unsigned RUN_LEN = 20;
  localparam int unsigned CNT_W   = $clog2(RUN_LEN);

  typedef enum logic [1:0] {
    ST_OK      = 2'd0,
    ST_NO_DEV  = 2'd1,
    ST_BAD_ARG = 2'd2,
    ST_NO_MEM  = 2'd3
  } status_e;

  typedef enum logic [1:0] {
    GRP_MISC = 2'd0,
    GRP_SEQ  = 2'd1,
    GRP_CRTC = 2'd2,
    GRP_DAC  = 2'd3
  } reg_group_e;

  typedef enum logic [7:0] {
    CFG_DEVICE_PRESENT = 8'd0,
    CFG_VRAM_BYTES     = 8'd1,
    CFG_SR07_HIGH      = 8'd2,
    CFG_CR1A_HIGH      = 8'd3,
    CFG_CR1B_CURRENT   = 8'd4
  } cfg_index_e;

  localparam logic [7:0] MISC_BASE     = 8'h23;
  localparam logic [7:0] MISC_HI_LINES = 8'hC0;
  localparam logic [7:0] MISC_LO_LINES = 8'h40;
  localparam logic [7:0] CR17_MODE     = 8'hC3;
  localparam logic [4:0] SR07_DEEP     = 5'h09;
  localparam logic [4:0] SR07_16BPP    = 5'h07;
  localparam logic [7:0] DAC_DEEP      = 8'hC5;
  localparam logic [7:0] DAC_16BPP     = 8'hC1;
  localparam logic [7:0] CR03_BASE     = 8'h80;
  localparam logic [10:0] HI_LINES_MIN = 11'd400;
  localparam logic [31:0] VRAM_RESET   = 32'd4194304;

  typedef logic [7:0] byte_arr_t [RUN_LEN];

  // group and index of each word in run order
  localparam logic [1:0] RUN_GROUP [RUN_LEN] = '{
    GRP_SEQ, GRP_DAC, GRP_MISC,
    GRP_CRTC, GRP_CRTC, GRP_CRTC, GRP_CRTC, GRP_CRTC, GRP_CRTC, GRP_CRTC, GRP_CRTC,
    GRP_CRTC, GRP_CRTC, GRP_CRTC, GRP_CRTC, GRP_CRTC, GRP_CRTC, GRP_CRTC, GRP_CRTC,
    GRP_CRTC
  };

  localparam logic [7:0] RUN_INDEX [RUN_LEN] = '{
    8'h07, 8'h00, 8'h00,
    8'h00, 8'h01, 8'h02, 8'h03, 8'h04, 8'h05, 8'h06, 8'h07,
    8'h09, 8'h10, 8'h12, 8'h15, 8'h16, 8'h1A, 8'h17, 8'h13,
    8'h1B
  };

endpackage

FILE: hdl/vga_mode_register_generator.sv
// channel | direction | handshake           | payload
// in      | input     | in_valid_i/ready_o  | width_i, height_i, depth_bits_i
// cfg     | input     | cfg_valid_i/ready_o | cfg_index_i, cfg_data_i
// out     | output    | out_valid_o/ready_i | status_o, reg_group_o, reg_index_o,
//         |           |                     | reg_value_o, pitch_bytes_o, last_o
//
// three stages (pitch and checks, frame size multiply and timing adds,
// memory compare and byte formatting) feed an output stage that emits
// one word a cycle while out_ready_i is high: 20 words per good request,
// 1 per failed request. the first word is offered once the request has passed
// stages 1, 2 and 3 into the output stage; the output word counter sets the sustained rate.
// reset clears valid bits and loads config defaults; a stalled output holds every full stage.
module vga_mode_register_generator (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [11:0] width_i,
  input  logic [10:0] height_i,
  input  logic [5:0]  depth_bits_i,
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [7:0]  cfg_index_i,
  input  logic [31:0] cfg_data_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [1:0]  status_o,
  output logic [1:0]  reg_group_o,
  output logic [7:0]  reg_index_o,
  output logic [7:0]  reg_value_o,
  output logic [13:0] pitch_bytes_o,
  output logic        last_o
);
  import vga_mrg_pkg::*;

  // config
  logic        dev_q;
  logic [31:0] vram_q;
  logic [2:0]  sr07_q;
  logic [1:0]  cr1a_q;
  logic [7:0]  cr1b_q;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      dev_q  <= 1'b1;
      vram_q <= VRAM_RESET;
      sr07_q <= '0;
      cr1a_q <= '0;
      cr1b_q <= '0;
    end else if (cfg_valid_i) begin
      unique case (cfg_index_i)
        CFG_DEVICE_PRESENT: dev_q  <= cfg_data_i[0];
        CFG_VRAM_BYTES:     vram_q <= cfg_data_i;
        CFG_SR07_HIGH:      sr07_q <= cfg_data_i[2:0];
        CFG_CR1A_HIGH:      cr1a_q <= cfg_data_i[1:0];
        CFG_CR1B_CURRENT:   cr1b_q <= cfg_data_i[7:0];
        default: ;
      endcase
    end
  end

  // stall chain
  logic s1_v_q, s2_v_q, s3_v_q, em_v_q;
  logic s1_rdy, s2_rdy, s3_rdy, em_rdy, em_last;

  assign em_rdy     = !em_v_q || (out_ready_i && em_last);
  assign s3_rdy     = !s3_v_q || em_rdy;
  assign s2_rdy     = !s2_v_q || s3_rdy;
  assign s1_rdy     = !s1_v_q || s2_rdy;
  assign in_ready_o = s1_rdy;

  // stage 1: checks and pitch
  status_e     s1_st_d, s1_st_q;
  logic [13:0] s1_pitch_d, s1_pitch_q;
  logic [11:0] s1_w_q;
  logic [10:0] s1_h_q;
  logic [5:0]  s1_dep_q;

  always_comb begin
    s1_st_d    = ST_OK;
    s1_pitch_d = '0;
    case (depth_bits_i)
      6'd16: s1_pitch_d = {1'b0, width_i, 1'b0};
      6'd24: s1_pitch_d = {2'b00, width_i} + {1'b0, width_i, 1'b0};
      6'd32: s1_pitch_d = {width_i, 2'b00};
      default: s1_st_d = ST_BAD_ARG;
    endcase
    if (width_i == '0 || height_i == '0) s1_st_d = ST_BAD_ARG;
    if (!dev_q) s1_st_d = ST_NO_DEV;
  end

  always_ff @(posedge clk_i) begin
    if (s1_rdy) begin
      s1_st_q    <= s1_st_d;
      s1_pitch_q <= s1_pitch_d;
      s1_w_q     <= width_i;
      s1_h_q     <= height_i;
      s1_dep_q   <= depth_bits_i;
    end
  end

  // stage 2: frame size and timing sums
  status_e     s2_st_q;
  logic [24:0] s2_need_q;
  logic [13:0] s2_pitch_q;
  logic [5:0]  s2_dep_q;
  logic        s2_hi_q;
  logic [7:0]  s2_hde_q, s2_hbs_q, s2_hss_q, s2_hse_q, s2_hbe_q, s2_ht_q;
  logic [10:0] s2_vde_q, s2_vbs_q, s2_vss_q, s2_vbe_q, s2_vt_q;
  logic [7:0]  h8;

  // low byte of the character count
  assign h8 = s1_w_q[10:3];

  always_ff @(posedge clk_i) begin
    if (s2_rdy) begin
      s2_st_q    <= s1_st_q;
      s2_need_q  <= 25'(s1_pitch_q) * 25'(s1_h_q);
      s2_pitch_q <= s1_pitch_q;
      s2_dep_q   <= s1_dep_q;
      s2_hi_q    <= s1_h_q >= HI_LINES_MIN;
      // horizontal values only need their low byte, so wrap is harmless
      s2_hde_q   <= h8 - 8'd1;
      s2_hbs_q   <= h8;
      s2_hss_q   <= h8 + 8'd1;
      s2_hse_q   <= h8 + 8'd13;
      s2_hbe_q   <= h8 + 8'd15;
      s2_ht_q    <= h8 + 8'd17;
      s2_vde_q   <= s1_h_q - 11'd1;
      s2_vbs_q   <= s1_h_q;
      s2_vss_q   <= s1_h_q + 11'd2;
      s2_vbe_q   <= s1_h_q + 11'd6;
      s2_vt_q    <= s1_h_q + 11'd8;
    end
  end

  // stage 3: memory check and byte formatting
  status_e     s3_st_d, s3_st_q;
  byte_arr_t   s3_b_d, s3_b_q;
  logic [13:0] s3_pitch_q;
  logic [10:0] offs;
  logic        too_big;

  assign offs    = s2_pitch_q[13:3];
  assign too_big = (vram_q != '0) && ({7'd0, s2_need_q} > vram_q);

  always_comb begin
    s3_st_d = s2_st_q;
    if (s2_st_q == ST_OK && too_big) s3_st_d = ST_NO_MEM;
    s3_b_d[0]  = {sr07_q, (s2_dep_q >= 6'd24) ? SR07_DEEP : SR07_16BPP};
    s3_b_d[1]  = (s2_dep_q == 6'd16) ? DAC_16BPP : DAC_DEEP;
    s3_b_d[2]  = MISC_BASE | (s2_hi_q ? MISC_HI_LINES : MISC_LO_LINES);
    s3_b_d[3]  = s2_ht_q;
    s3_b_d[4]  = s2_hde_q;
    s3_b_d[5]  = s2_hbs_q;
    s3_b_d[6]  = CR03_BASE | {3'b000, s2_hbe_q[4:0]};
    s3_b_d[7]  = s2_hss_q;
    s3_b_d[8]  = {s2_hbe_q[5], 2'b00, s2_hse_q[4:0]};
    s3_b_d[9]  = s2_vt_q[7:0];
    s3_b_d[10] = {s2_vss_q[9], s2_vde_q[9], s2_vt_q[9], 1'b0,
                  s2_vbs_q[8], s2_vss_q[8], s2_vde_q[8], s2_vt_q[8]};
    s3_b_d[11] = {2'b00, s2_vbs_q[9], 5'b00000};
    s3_b_d[12] = s2_vss_q[7:0];
    s3_b_d[13] = s2_vde_q[7:0];
    s3_b_d[14] = s2_vbs_q[7:0];
    s3_b_d[15] = s2_vbe_q[7:0];
    s3_b_d[16] = {cr1a_q, 2'b00, s2_vss_q[8], s2_vde_q[8], s2_vt_q[8], s2_vbs_q[8]};
    s3_b_d[17] = CR17_MODE;
    s3_b_d[18] = offs[7:0];
    s3_b_d[19] = {cr1b_q[7:5], offs[8], cr1b_q[3:0]};
  end

  always_ff @(posedge clk_i) begin
    if (s3_rdy) begin
      s3_st_q    <= s3_st_d;
      s3_b_q     <= s3_b_d;
      s3_pitch_q <= s2_pitch_q;
    end
  end

  // output stage: walks the run one word at a time
  status_e          em_st_q;
  byte_arr_t        em_b_q;
  logic [13:0]      em_pitch_q;
  logic [CNT_W-1:0] cnt_d, cnt_q;
  logic             em_ok, out_fire;

  assign em_ok    = em_st_q == ST_OK;
  assign em_last  = !em_ok || (cnt_q == CNT_W'(RUN_LEN - 1));
  assign out_fire = em_v_q && out_ready_i;

  always_comb begin
    cnt_d = cnt_q;
    if (em_rdy) cnt_d = '0;
    else if (out_fire) cnt_d = cnt_q + CNT_W'(1);
  end

  always_ff @(posedge clk_i) begin
    if (em_rdy) begin
      em_st_q    <= s3_st_q;
      em_b_q     <= s3_b_q;
      em_pitch_q <= s3_pitch_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_v_q <= 1'b0;
      s2_v_q <= 1'b0;
      s3_v_q <= 1'b0;
      em_v_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      if (s1_rdy) s1_v_q <= in_valid_i;
      if (s2_rdy) s2_v_q <= s1_v_q;
      if (s3_rdy) s3_v_q <= s2_v_q;
      if (em_rdy) em_v_q <= s3_v_q;
      cnt_q <= cnt_d;
    end
  end

  assign out_valid_o   = em_v_q;
  assign status_o      = em_st_q;
  assign reg_group_o   = em_ok ? RUN_GROUP[cnt_q] : GRP_MISC;
  assign reg_index_o   = em_ok ? RUN_INDEX[cnt_q] : 8'd0;
  assign reg_value_o   = em_ok ? em_b_q[cnt_q] : 8'd0;
  assign pitch_bytes_o = em_ok ? em_pitch_q : 14'd0;
  assign last_o        = em_last;

  // a failed request is a single word
  a_fail_single : assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (status_o != ST_OK) |-> last_o)
    else $error("failed request word not marked last");

  // a run never breaks off midway
  a_run_continues : assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_ready_i && !last_o |=> out_valid_o && (status_o == ST_OK))
    else $error("register run interrupted");

  // pitch is the same on every word of a run
  a_pitch_stable : assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_ready_i && !last_o |=> $stable(pitch_bytes_o))
    else $error("pitch changed inside a run");

  // the last word of a good run is the twentieth
  a_run_length : assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (status_o == ST_OK) && last_o |-> reg_index_o == RUN_INDEX[RUN_LEN - 1])
    else $error("good run ended early");

endmodule
